FILE: rtl/bpra_pkg.sv
// Shared constants for the bitmap page run allocator.
// Status codes, action codes, register indexes and default sizes; no dependencies.
package bpra_pkg;

    localparam int MAP_PAGES_DEF = 1024;
    localparam int MAX_RUN_DEF   = 64;

    localparam int ADDR_W   = 32;
    localparam int PAGE_W   = 21;
    localparam int COUNT_W  = 11;
    localparam int LEN_W    = 7;
    localparam int STATUS_W = 2;
    localparam int PADDR_W  = 4;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_ROOM = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OUTSIDE = 2'd2;

    localparam logic [1:0] REG_BASE  = 2'd0;
    localparam logic [1:0] REG_PAGE  = 2'd1;
    localparam logic [1:0] REG_COUNT = 2'd2;

endpackage

FILE: rtl/bitmap_page_run_allocator.sv
// Bitmap page run allocator: top level with control sequencer and register port.
// Depends on bpra_pkg and bpra_ram.
//
// The used-page bitmap sits in a one-bit-wide RAM of MAP_PAGES entries. After
// reset a clearing pass writes every entry, during which no item is taken.
// One item is worked at a time. An allocate scans one page per cycle from the
// search hint through the RAM read port, then marks the run one page at a time
// and forms the address with a multiply and an add. A free runs a bit-serial
// divider, one check step and then clears the run one page at a time. Results
// leave through an output register; while a result waits there the sequencer
// holds in S_OUT and takes no new item.
module bitmap_page_run_allocator #(
    parameter int MAP_PAGES = bpra_pkg::MAP_PAGES_DEF,
    parameter int MAX_RUN   = bpra_pkg::MAX_RUN_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [bpra_pkg::PADDR_W-1:0]    paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            action,
    input  logic [bpra_pkg::LEN_W-1:0]      run_length,
    input  logic [bpra_pkg::ADDR_W-1:0]     free_address,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [bpra_pkg::ADDR_W-1:0]     granted_address,
    output logic [bpra_pkg::STATUS_W-1:0]   status
);
    import bpra_pkg::*;

    localparam int AW = $clog2(MAP_PAGES);
    localparam int IW = $clog2(MAP_PAGES + 1);
    localparam int PW = IW + PAGE_W;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_SCAN, S_MARK, S_MUL, S_ADD,
        S_DIV, S_CHECK, S_FREE, S_OUT
    } state_t;

    state_t                state_reg, state_next;
    logic [ADDR_W-1:0]     base_reg;
    logic [PAGE_W-1:0]     page_reg;
    logic [COUNT_W-1:0]    count_cfg_reg;
    logic [IW-1:0]         hint_reg, hint_next;
    logic [IW-1:0]         ptr_reg, ptr_next;
    logic                  chk_valid_reg, chk_valid_next;
    logic [IW-1:0]         chk_idx_reg, chk_idx_next;
    logic [LEN_W-1:0]      run_reg, run_next;
    logic [LEN_W-1:0]      len_reg, len_next;
    logic [LEN_W-1:0]      left_reg, left_next;
    logic [PW-1:0]         prod_reg, prod_next;
    logic [ADDR_W-1:0]     num_reg, num_next;
    logic [PAGE_W:0]       rem_reg, rem_next;
    logic [ADDR_W-1:0]     quo_reg, quo_next;
    logic [4:0]            div_cnt_reg, div_cnt_next;
    logic [ADDR_W-1:0]     res_addr_reg, res_addr_next;
    logic [STATUS_W-1:0]   res_status_reg, res_status_next;
    logic                  out_valid_reg;
    logic [ADDR_W-1:0]     out_addr_reg;
    logic [STATUS_W-1:0]   out_status_reg;

    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic                  mem_wdata;
    logic [AW-1:0]         mem_raddr;
    logic                  mem_rdata;

    logic [31:0]           limit_w;
    logic [IW-1:0]         limit;
    logic [PAGE_W-1:0]     divisor;
    logic [PAGE_W:0]       rem_shift;
    logic                  cfg_write;
    logic                  out_free;

    // Effective page count and divisor
    assign limit_w = (32'(count_cfg_reg) > 32'(MAP_PAGES)) ? 32'(MAP_PAGES)
                                                           : 32'(count_cfg_reg);
    assign limit   = limit_w[IW-1:0];
    assign divisor = (page_reg == '0) ? PAGE_W'(1) : page_reg;

    assign rem_shift = {rem_reg[PAGE_W-1:0], num_reg[ADDR_W-1]};
    assign out_free  = !out_valid_reg || !out_stall;

    // Register port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        case (paddr[3:2])
            REG_BASE:  prdata = base_reg;
            REG_PAGE:  prdata = 32'(page_reg);
            REG_COUNT: prdata = 32'(count_cfg_reg);
            default:   prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg      <= '0;
            page_reg      <= PAGE_W'(4096);
            count_cfg_reg <= COUNT_W'(1024);
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                REG_BASE:  base_reg      <= pwdata;
                REG_PAGE:  page_reg      <= pwdata[PAGE_W-1:0];
                REG_COUNT: count_cfg_reg <= pwdata[COUNT_W-1:0];
                default:   ;
            endcase
        end
    end

    // Bitmap storage
    bpra_ram #(
        .WIDTH(1),
        .DEPTH(MAP_PAGES)
    ) u_map (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign in_stall = (state_reg != S_IDLE);

    // Sequencer next state
    always_comb
    begin
        state_next      = state_reg;
        hint_next       = hint_reg;
        ptr_next        = ptr_reg;
        chk_valid_next  = 1'b0;
        chk_idx_next    = chk_idx_reg;
        run_next        = run_reg;
        len_next        = len_reg;
        left_next       = left_reg;
        prod_next       = prod_reg;
        num_next        = num_reg;
        rem_next        = rem_reg;
        quo_next        = quo_reg;
        div_cnt_next    = div_cnt_reg;
        res_addr_next   = res_addr_reg;
        res_status_next = res_status_reg;
        mem_we          = 1'b0;
        mem_waddr       = ptr_reg[AW-1:0];
        mem_wdata       = 1'b0;
        mem_raddr       = ptr_reg[AW-1:0];

        case (state_reg)
            S_CLEAR:
            begin
                mem_we = 1'b1;
                if (32'(ptr_reg) == 32'(MAP_PAGES - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    ptr_next = ptr_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    len_next        = run_length;
                    left_next       = run_length;
                    res_addr_next   = '0;
                    run_next        = '0;
                    ptr_next        = hint_reg;
                    if (action == ACT_ALLOC)
                    begin
                        res_status_next = ST_NO_ROOM;
                        if (run_length == '0 || 32'(run_length) > 32'(MAX_RUN))
                        begin
                            state_next = S_OUT;
                        end
                        else
                        begin
                            state_next = S_SCAN;
                        end
                    end
                    else
                    begin
                        res_status_next = ST_OK;
                        num_next        = free_address - base_reg;
                        rem_next        = '0;
                        quo_next        = '0;
                        div_cnt_next    = '0;
                        if (run_length == '0)
                        begin
                            state_next = S_OUT;
                        end
                        else if (32'(run_length) > 32'(MAX_RUN) || free_address < base_reg)
                        begin
                            res_status_next = ST_OUTSIDE;
                            state_next      = S_OUT;
                        end
                        else
                        begin
                            state_next = S_DIV;
                        end
                    end
                end
            end
            S_SCAN:
            begin
                // Issue the next read, then check the bit read last cycle
                if (ptr_reg < limit)
                begin
                    chk_valid_next = 1'b1;
                    chk_idx_next   = ptr_reg;
                    ptr_next       = ptr_reg + 1'b1;
                end
                if (chk_valid_reg)
                begin
                    if (mem_rdata)
                    begin
                        run_next = '0;
                    end
                    else if (run_reg + 1'b1 == len_reg)
                    begin
                        chk_valid_next = 1'b0;
                        ptr_next       = chk_idx_reg + 1'b1 - IW'(len_reg);
                        hint_next      = chk_idx_reg + 1'b1;
                        state_next     = S_MARK;
                    end
                    else
                    begin
                        run_next = run_reg + 1'b1;
                    end
                end
                else if (ptr_reg >= limit)
                begin
                    state_next = S_OUT;
                end
            end
            S_MARK:
            begin
                mem_we    = 1'b1;
                mem_wdata = 1'b1;
                if (left_reg == LEN_W'(1))
                begin
                    ptr_next   = ptr_reg + 1'b1 - IW'(len_reg);
                    state_next = S_MUL;
                end
                else
                begin
                    ptr_next  = ptr_reg + 1'b1;
                    left_next = left_reg - 1'b1;
                end
            end
            S_MUL:
            begin
                prod_next  = PW'(ptr_reg) * PW'(divisor);
                state_next = S_ADD;
            end
            S_ADD:
            begin
                res_addr_next   = base_reg + 32'(prod_reg);
                res_status_next = ST_OK;
                state_next      = S_OUT;
            end
            S_DIV:
            begin
                // One quotient bit per cycle
                num_next = {num_reg[ADDR_W-2:0], 1'b0};
                if (rem_shift >= {1'b0, divisor})
                begin
                    rem_next = rem_shift - {1'b0, divisor};
                    quo_next = {quo_reg[ADDR_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_shift;
                    quo_next = {quo_reg[ADDR_W-2:0], 1'b0};
                end
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == 5'd31)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (quo_reg >= limit_w || 32'(len_reg) > limit_w - quo_reg)
                begin
                    res_status_next = ST_OUTSIDE;
                    state_next      = S_OUT;
                end
                else
                begin
                    ptr_next   = quo_reg[IW-1:0];
                    if (quo_reg[IW-1:0] < hint_reg)
                    begin
                        hint_next = quo_reg[IW-1:0];
                    end
                    state_next = S_FREE;
                end
            end
            S_FREE:
            begin
                mem_we = 1'b1;
                ptr_next = ptr_reg + 1'b1;
                if (left_reg == LEN_W'(1))
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    left_next = left_reg - 1'b1;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state, control and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            hint_reg       <= '0;
            ptr_reg        <= '0;
            chk_valid_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_addr_reg   <= '0;
            out_status_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            hint_reg      <= hint_next;
            ptr_reg       <= ptr_next;
            chk_valid_reg <= chk_valid_next;
            if (state_reg == S_OUT && out_free)
            begin
                out_valid_reg  <= 1'b1;
                out_addr_reg   <= res_addr_reg;
                out_status_reg <= res_status_reg;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        chk_idx_reg    <= chk_idx_next;
        run_reg        <= run_next;
        len_reg        <= len_next;
        left_reg       <= left_next;
        prod_reg       <= prod_next;
        num_reg        <= num_next;
        rem_reg        <= rem_next;
        quo_reg        <= quo_next;
        div_cnt_reg    <= div_cnt_next;
        res_addr_reg   <= res_addr_next;
        res_status_reg <= res_status_next;
    end

    assign out_valid       = out_valid_reg;
    assign granted_address = out_addr_reg;
    assign status          = out_status_reg;

    // Checks
    a_fail_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> granted_address == '0)
        else $error("failed result carries an address");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == ST_OK || status == ST_NO_ROOM || status == ST_OUTSIDE))
        else $error("unknown status code");

    a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == S_CLEAR || state_reg == S_MARK || state_reg == S_FREE))
        else $error("bitmap written outside a write state");

    a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN && chk_valid_reg |-> chk_idx_reg < limit)
        else $error("scan checked a page past the range");

endmodule

FILE: rtl/bpra_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
module bpra_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: tb/bitmap_page_run_allocator_tb.sv
// Self-checking testbench for the bitmap page run allocator.
// Depends on bpra_pkg and the allocator RTL; a bitmap predictor sets the expected beats.
module bitmap_page_run_allocator_tb;
    import bpra_pkg::*;

    localparam int MAP_PAGES  = MAP_PAGES_DEF;
    localparam int MAX_RUN    = MAX_RUN_DEF;
    localparam int IDLE_LIMIT = 20000;

    typedef enum logic [1:0] {
        K_RAW,
        K_LIVE,
        K_INMAP
    } req_kind_t;

    typedef struct {
        logic              act;
        logic [LEN_W-1:0]  len;
        logic [ADDR_W-1:0] addr;
        req_kind_t         kind;
    } page_req_t;

    typedef struct {
        logic [ADDR_W-1:0]   addr;
        logic [STATUS_W-1:0] st;
    } grant_t;

    typedef struct {
        logic [ADDR_W-1:0] addr;
        logic [LEN_W-1:0]  len;
    } live_run_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic in_valid = 1'b0;
    logic in_stall;
    logic action = ACT_ALLOC;
    logic [LEN_W-1:0] run_length = '0;
    logic [ADDR_W-1:0] free_address = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [ADDR_W-1:0] granted_address;
    logic [STATUS_W-1:0] status;

    // predictor state
    logic        page_used [MAP_PAGES];
    int unsigned hint_idx;
    logic [31:0] cfg_base;
    logic [20:0] cfg_page;
    logic [10:0] cfg_count;

    page_req_t   pending_reqs[$];
    grant_t      expected_grants[$];
    live_run_t   live_runs[$];
    int          fail_count = 0;
    int          idle_cycles = 0;
    int          in_gap = 0;
    int          out_gap = 0;
    bit          calm = 1'b0;

    bitmap_page_run_allocator uut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_stall(in_stall),
        .action(action), .run_length(run_length), .free_address(free_address),
        .out_valid(out_valid), .out_stall(out_stall),
        .granted_address(granted_address), .status(status)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic int unsigned managed_limit();
        return (cfg_count > MAP_PAGES) ? MAP_PAGES : int'(cfg_count);
    endfunction

    function automatic logic [31:0] page_div();
        return (cfg_page == 0) ? 32'd1 : {11'd0, cfg_page};
    endfunction

    // Work out one result and update the bitmap, as the block would
    function automatic grant_t predict_grant(page_req_t r);
        grant_t      g;
        int unsigned lim;
        int unsigned cnt;
        int unsigned start;
        logic [31:0] idx;
        live_run_t   lr;
        lim = managed_limit();
        cnt = 0;
        g.addr = '0;
        if (r.act == ACT_ALLOC)
        begin
            g.st = ST_NO_ROOM;
            if (r.len != 0 && r.len <= MAX_RUN)
            begin
                for (int unsigned i = hint_idx; i < lim; i++)
                begin
                    if (page_used[i])
                        cnt = 0;
                    else
                    begin
                        cnt++;
                        if (cnt == r.len)
                        begin
                            start = i + 1 - r.len;
                            for (int unsigned j = start; j <= i; j++)
                                page_used[j] = 1'b1;
                            hint_idx = i + 1;
                            g.addr = cfg_base + 32'(start) * page_div();
                            g.st = ST_OK;
                            lr.addr = g.addr;
                            lr.len = r.len;
                            live_runs.push_back(lr);
                            break;
                        end
                    end
                end
            end
        end
        else
        begin
            g.st = ST_OK;
            if (r.len != 0)
            begin
                if (r.len > MAX_RUN || r.addr < cfg_base)
                    g.st = ST_OUTSIDE;
                else
                begin
                    idx = (r.addr - cfg_base) / page_div();
                    if (idx >= lim || r.len > lim - idx)
                        g.st = ST_OUTSIDE;
                    else
                    begin
                        for (int unsigned j = 0; j < r.len; j++)
                            page_used[idx + j] = 1'b0;
                        if (idx < hint_idx)
                            hint_idx = idx;
                    end
                end
            end
        end
        return g;
    endfunction

    // Fill in addresses that depend on what has been granted so far
    function automatic page_req_t resolve_req(page_req_t r);
        int unsigned k;
        int unsigned lim;
        if (r.kind == K_LIVE)
        begin
            if (live_runs.size() == 0)
            begin
                r.act = ACT_ALLOC;
                r.len = LEN_W'($urandom_range(1, 8));
            end
            else
            begin
                k = $urandom_range(0, live_runs.size() - 1);
                r.addr = live_runs[k].addr;
                r.len = live_runs[k].len;
                live_runs.delete(k);
            end
        end
        else if (r.kind == K_INMAP)
        begin
            lim = managed_limit();
            k = (lim == 0) ? 0 : $urandom_range(0, lim - 1);
            r.addr = cfg_base + 32'(k) * page_div();
        end
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
        fail_count++;
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= PADDR_W'({idx, 2'b00});
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_BASE:  cfg_base = val;
            REG_PAGE:  cfg_page = val[20:0];
            REG_COUNT: cfg_count = val[10:0];
            default: ;
        endcase
    endtask

    task automatic add_req(logic a, int len, logic [31:0] addr, req_kind_t k);
        page_req_t r;
        r.act = a;
        r.len = LEN_W'(len);
        r.addr = addr;
        r.kind = k;
        pending_reqs.push_back(r);
    endtask

    // Mostly allocs and frees of granted runs, some in-map frees and noise
    task automatic add_random(int n);
        int r;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 45)
                add_req(ACT_ALLOC, ($urandom_range(0, 9) == 0) ? $urandom_range(1, 64)
                        : $urandom_range(1, 8), '0, K_RAW);
            else if (r < 75)
                add_req(ACT_FREE, 0, '0, K_LIVE);
            else if (r < 90)
                add_req(ACT_FREE, $urandom_range(1, 8), '0, K_INMAP);
            else
                add_req(1'($urandom), $urandom_range(0, 127), $urandom, K_RAW);
        end
    endtask

    task automatic wait_idle();
        while (pending_reqs.size() != 0 || in_valid || expected_grants.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_config(logic [31:0] b, logic [31:0] p, logic [31:0] c);
        write_reg(REG_BASE, b);
        write_reg(REG_PAGE, p);
        write_reg(REG_COUNT, c);
        live_runs.delete();
    endtask

    // Request driver: present the next beat once the current one is taken
    always @(posedge clk or negedge rst_n)
    begin
        page_req_t r;
        grant_t    g;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                r.act = action;
                r.len = run_length;
                r.addr = free_address;
                r.kind = K_RAW;
                g = predict_grant(r);
                expected_grants.push_back(g);
            end
            if (!in_valid || !in_stall)
            begin
                if (in_gap > 0 || pending_reqs.size() == 0)
                begin
                    if (in_gap > 0)
                        in_gap <= in_gap - 1;
                    in_valid <= 1'b0;
                end
                else
                begin
                    r = resolve_req(pending_reqs.pop_front());
                    action <= r.act;
                    run_length <= r.len;
                    free_address <= r.addr;
                    in_valid <= 1'b1;
                    in_gap <= pick_gap();
                end
            end
        end
    end

    // Result monitor and receiver stalls
    always @(posedge clk)
    begin
        grant_t g;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_grants.size() == 0)
                    report_mismatch("unexpected beat", granted_address, '0);
                else
                begin
                    g = expected_grants.pop_front();
                    if (granted_address !== g.addr)
                        report_mismatch("granted_address", granted_address, g.addr);
                    if (status !== g.st)
                        report_mismatch("status", 32'(status), 32'(g.st));
                end
            end
            if (out_gap > 0)
            begin
                out_stall <= 1'b1;
                out_gap <= out_gap - 1;
            end
            else
            begin
                out_stall <= 1'b0;
                out_gap <= pick_gap();
            end
            if ($urandom_range(0, 299) == 0)
                calm <= ~calm;
        end
    end

    // Watchdog on handshake progress
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        for (int i = 0; i < MAP_PAGES; i++)
            page_used[i] = 1'b0;
        hint_idx = 0;
        cfg_base = 32'd0;
        cfg_page = 21'd4096;
        cfg_count = 11'd1024;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed: length extremes, bad lengths, frees outside the map
        set_config(32'd0, 32'd4096, 32'd1024);
        add_req(ACT_ALLOC, 1, '0, K_RAW);
        add_req(ACT_ALLOC, 64, '0, K_RAW);
        add_req(ACT_ALLOC, 0, '0, K_RAW);
        add_req(ACT_ALLOC, 65, '0, K_RAW);
        add_req(ACT_ALLOC, 127, 32'hFFFF_FFFF, K_RAW);
        add_req(ACT_FREE, 0, '0, K_LIVE);
        add_req(ACT_FREE, 0, 32'd4096, K_RAW);
        add_req(ACT_FREE, 65, 32'd0, K_RAW);
        add_req(ACT_FREE, 127, 32'd0, K_RAW);
        add_req(ACT_FREE, 2, 32'd1023 * 4096, K_RAW);
        add_req(ACT_FREE, 1, 32'd1023 * 4096, K_RAW);
        add_req(ACT_FREE, 1, 32'hFFFF_FFFF, K_RAW);
        add_req(ACT_FREE, 64, 32'd0, K_RAW);
        add_random(280);
        wait_idle();

        // page size of 1048576 with addresses that wrap
        set_config(32'hFFF0_0000, 32'd1048576, 32'd200);
        add_req(ACT_FREE, 1, 32'h0000_0000, K_RAW);
        add_random(300);
        wait_idle();

        // zero page size, small map, hint likely beyond the range
        set_config(32'h0000_1000, 32'd0, 32'd48);
        add_req(ACT_ALLOC, 1, '0, K_RAW);
        add_req(ACT_FREE, 1, 32'h0000_0FFF, K_RAW);
        add_random(300);
        wait_idle();

        // oversized page count, page size one
        set_config(32'h8000_0000, 32'd1, 32'd2047);
        add_random(300);
        wait_idle();

        // zero page count: nothing is managed
        set_config(32'd12345, 32'd7, 32'd0);
        add_req(ACT_ALLOC, 1, '0, K_RAW);
        add_req(ACT_FREE, 1, 32'd12345, K_RAW);
        add_req(ACT_FREE, 0, 32'd12345, K_RAW);
        add_random(30);
        wait_idle();

        // one page: runs of two cannot fit at the map end
        set_config(32'h1234_5678, 32'd3, 32'd1);
        add_req(ACT_FREE, 1, 32'h1234_5678, K_RAW);
        add_req(ACT_ALLOC, 2, '0, K_RAW);
        add_req(ACT_ALLOC, 1, '0, K_RAW);
        add_req(ACT_ALLOC, 1, '0, K_RAW);
        add_random(100);
        wait_idle();

        set_config(32'd0, 32'd4096, 32'd100);
        add_random(500);
        wait_idle();
        repeat (20) @(posedge clk);

        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
